FILE: sv/pcfd_pkg.sv
// Shared types, constants and register indexes for the phase current fault detector.
// Used by every module of the block; depends on nothing.
package pcfd_pkg;

    localparam int METERS_DEFAULT = 4;

    localparam int METER_W    = 2;
    localparam int CUR_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AVG_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd4;

    localparam logic [CUR_W-1:0]   AVG_HIGH_RESET    = 16'd700;
    localparam logic [CUR_W-1:0]   AVG_LOW_RESET     = 16'd360;
    localparam logic [RATIO_W-1:0] UPPER_RATIO_RESET = 8'd12;
    localparam logic [RATIO_W-1:0] LOWER_RATIO_RESET = 8'd8;
    localparam logic [TIME_W-1:0]  HOLD_RESET        = 32'd3000;

    typedef struct packed {
        logic [CUR_W-1:0]   avg_high_limit;
        logic [CUR_W-1:0]   avg_low_limit;
        logic [RATIO_W-1:0] upper_ratio_tenths;
        logic [RATIO_W-1:0] lower_ratio_tenths;
        logic [TIME_W-1:0]  hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [METER_W-1:0] meter;
        logic               abnormal;
        logic [TIME_W-1:0]  now;
    } screen_t;

endpackage

FILE: sv/pcfd_screen.sv
// Input register and current screening stage of the phase current fault detector.
// Decides whether a reading is abnormal; depends on pcfd_pkg.
module pcfd_screen (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcfd_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pcfd_pkg::METER_W-1:0]        meter_index,
    input  logic [pcfd_pkg::CUR_W-1:0]          phase_a_current,
    input  logic [pcfd_pkg::CUR_W-1:0]          phase_b_current,
    input  logic [pcfd_pkg::CUR_W-1:0]          phase_c_current,
    input  logic [pcfd_pkg::CUR_W-1:0]          average_current,
    input  logic [pcfd_pkg::TIME_W-1:0]         now_ms,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output pcfd_pkg::screen_t                   dn_data
);

    logic                              s1_valid_reg;
    logic [pcfd_pkg::METER_W-1:0]      meter_reg;
    logic [pcfd_pkg::CUR_W-1:0]        a_reg;
    logic [pcfd_pkg::CUR_W-1:0]        b_reg;
    logic [pcfd_pkg::CUR_W-1:0]        c_reg;
    logic [pcfd_pkg::CUR_W-1:0]        avg_reg;
    logic [pcfd_pkg::TIME_W-1:0]       now_reg;
    logic                              s2_valid_reg;
    pcfd_pkg::screen_t                 s2_data_reg;
    pcfd_pkg::screen_t                 s2_data_next;

    logic                              s1_ready;
    logic                              s2_ready;
    logic [pcfd_pkg::CUR_W-1:0]        hi;
    logic [pcfd_pkg::CUR_W-1:0]        lo;
    logic [23:0]                       prod_up;
    logic [23:0]                       prod_lo;
    logic [19:0]                       hi_x10;
    logic [20:0]                       lo_x10_p10;
    logic                              abnormal;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        hi = a_reg;
        lo = a_reg;
        if (b_reg > hi)
        begin
            hi = b_reg;
        end
        if (c_reg > hi)
        begin
            hi = c_reg;
        end
        if (b_reg < lo)
        begin
            lo = b_reg;
        end
        if (c_reg < lo)
        begin
            lo = c_reg;
        end
    end

    // A phase exceeds floor(p/10) exactly when ten times the phase exceeds p, and a phase
    // is below floor(p/10) exactly when ten times the phase plus ten is at most p.
    assign prod_up    = {8'd0, avg_reg} * {16'd0, cfg.upper_ratio_tenths};
    assign prod_lo    = {8'd0, avg_reg} * {16'd0, cfg.lower_ratio_tenths};
    assign hi_x10     = (20'(hi) << 3) + (20'(hi) << 1);
    assign lo_x10_p10 = (21'(lo) << 3) + (21'(lo) << 1) + 21'd10;

    assign abnormal = (avg_reg > cfg.avg_high_limit)
                   || ((avg_reg != '0) && (avg_reg < cfg.avg_low_limit))
                   || ({4'd0, hi_x10} > prod_up)
                   || ((lo != '0) && ({3'd0, lo_x10_p10} <= prod_lo));

    always_comb
    begin
        s2_data_next.meter    = meter_reg;
        s2_data_next.abnormal = abnormal;
        s2_data_next.now      = now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            meter_reg <= meter_index;
            a_reg     <= phase_a_current;
            b_reg     <= phase_b_current;
            c_reg     <= phase_c_current;
            avg_reg   <= average_current;
            now_reg   <= now_ms;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

endmodule

FILE: sv/pcfd_tracker.sv
// Per-meter hold timer and result register of the phase current fault detector.
// Keeps the arm flags and start times; depends on pcfd_pkg.
module pcfd_tracker #(
    parameter int METERS = pcfd_pkg::METERS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pcfd_pkg::TIME_W-1:0] hold_ms,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  pcfd_pkg::screen_t           up_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        fault
);

    localparam int MIDX_W = (METERS > 1) ? $clog2(METERS) : 1;

    logic                        armed_reg [METERS];
    logic [pcfd_pkg::TIME_W-1:0] start_reg [METERS];
    logic                        out_valid_reg;
    logic                        fault_reg;
    logic                        fault_next;

    logic                        advance;
    logic                        in_range;
    logic [MIDX_W-1:0]           idx;
    logic                        armed_cur;
    logic [pcfd_pkg::TIME_W-1:0] start_cur;
    logic [pcfd_pkg::TIME_W-1:0] elapsed;
    logic                        over_hold;

    assign up_ready = !out_valid_reg || out_ready;
    assign advance  = up_valid && up_ready;
    assign in_range = (32'(up_data.meter) < 32'(METERS));
    assign idx      = MIDX_W'(up_data.meter);

    // An armed meter starts its episode with this reading, so its elapsed time is zero.
    assign armed_cur  = in_range ? armed_reg[idx] : 1'b0;
    assign start_cur  = armed_cur ? up_data.now : (in_range ? start_reg[idx] : up_data.now);
    assign elapsed    = up_data.now - start_cur;
    assign over_hold  = elapsed > hold_ms;
    assign fault_next = in_range && up_data.abnormal && over_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < METERS; i++)
            begin
                armed_reg[i] <= 1'b1;
                start_reg[i] <= '0;
            end
        end
        else
        begin
            if (up_ready)
            begin
                out_valid_reg <= up_valid;
            end
            if (advance && in_range)
            begin
                if (up_data.abnormal)
                begin
                    start_reg[idx] <= start_cur;
                    if (!over_hold)
                    begin
                        armed_reg[idx] <= 1'b0;
                    end
                end
                else
                begin
                    armed_reg[idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_reg <= fault_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fault     = fault_reg;

endmodule

FILE: sv/phase_current_fault_detector.sv
// Top level of the phase current fault detector: configuration registers and the two stages.
// Depends on pcfd_pkg, pcfd_screen and pcfd_tracker.
//
// Each accepted item is one meter reading and yields one fault item via the input, screening and
// output registers. While the output is taken, a new reading can be accepted in every cycle; the
// throughput is one item per clock, set by the per-meter state update in the last stage.
// Configuration writes are taken in any cycle and must only be made while the block is idle.
module phase_current_fault_detector #(
    parameter int METERS = pcfd_pkg::METERS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pcfd_pkg::METER_W-1:0]       meter_index,
    input  logic [pcfd_pkg::CUR_W-1:0]         phase_a_current,
    input  logic [pcfd_pkg::CUR_W-1:0]         phase_b_current,
    input  logic [pcfd_pkg::CUR_W-1:0]         phase_c_current,
    input  logic [pcfd_pkg::CUR_W-1:0]         average_current,
    input  logic [pcfd_pkg::TIME_W-1:0]        now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               fault
);

    pcfd_pkg::cfg_t    cfg_reg;
    logic              mid_valid;
    logic              mid_ready;
    pcfd_pkg::screen_t mid_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_high_limit     <= pcfd_pkg::AVG_HIGH_RESET;
            cfg_reg.avg_low_limit      <= pcfd_pkg::AVG_LOW_RESET;
            cfg_reg.upper_ratio_tenths <= pcfd_pkg::UPPER_RATIO_RESET;
            cfg_reg.lower_ratio_tenths <= pcfd_pkg::LOWER_RATIO_RESET;
            cfg_reg.hold_ms            <= pcfd_pkg::HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcfd_pkg::REG_AVG_HIGH:
                begin
                    cfg_reg.avg_high_limit <= cfg_data[pcfd_pkg::CUR_W-1:0];
                end
                pcfd_pkg::REG_AVG_LOW:
                begin
                    cfg_reg.avg_low_limit <= cfg_data[pcfd_pkg::CUR_W-1:0];
                end
                pcfd_pkg::REG_UPPER_RATIO:
                begin
                    cfg_reg.upper_ratio_tenths <= cfg_data[pcfd_pkg::RATIO_W-1:0];
                end
                pcfd_pkg::REG_LOWER_RATIO:
                begin
                    cfg_reg.lower_ratio_tenths <= cfg_data[pcfd_pkg::RATIO_W-1:0];
                end
                pcfd_pkg::REG_HOLD:
                begin
                    cfg_reg.hold_ms <= cfg_data[pcfd_pkg::TIME_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    pcfd_screen u_screen (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .meter_index     (meter_index),
        .phase_a_current (phase_a_current),
        .phase_b_current (phase_b_current),
        .phase_c_current (phase_c_current),
        .average_current (average_current),
        .now_ms          (now_ms),
        .dn_valid        (mid_valid),
        .dn_ready        (mid_ready),
        .dn_data         (mid_data)
    );

    pcfd_tracker #(
        .METERS (METERS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold_ms   (cfg_reg.hold_ms),
        .up_valid  (mid_valid),
        .up_ready  (mid_ready),
        .up_data   (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fault     (fault)
    );

    // An empty output register always lets the whole pipeline move.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output register is empty");

    // Elapsed time can never exceed the largest hold time.
    a_no_fault_at_max_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cfg_reg.hold_ms == '1)) |-> !fault)
        else $error("fault reported with the largest hold time");

    // A result only appears after an item has left the screening stage.
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(mid_valid))
        else $error("result item without a screened item");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for phase_current_fault_detector: directed and random meter readings,
// configuration sweeps and output back-pressure, each fault item checked against a local predictor.
// Depends on pcfd_pkg and the phase_current_fault_detector RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_METERS = pcfd_pkg::METERS_DEFAULT;
    localparam int METER_W = pcfd_pkg::METER_W;
    localparam int CUR_W = pcfd_pkg::CUR_W;
    localparam int RATIO_W = pcfd_pkg::RATIO_W;
    localparam int TIME_W = pcfd_pkg::TIME_W;
    localparam int CFG_IDX_W = pcfd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pcfd_pkg::CFG_DATA_W;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 320;

    typedef enum int {
        READ_NORMAL,
        READ_AVG_HIGH,
        READ_AVG_LOW,
        READ_PHASE_HIGH,
        READ_PHASE_LOW,
        READ_NOISE
    } reading_kind_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [METER_W-1:0]    meter_index = '0;
    logic [CUR_W-1:0]      phase_a_current = '0;
    logic [CUR_W-1:0]      phase_b_current = '0;
    logic [CUR_W-1:0]      phase_c_current = '0;
    logic [CUR_W-1:0]      average_current = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  fault;

    // Local copy of the configuration and the per-meter tracking state.
    logic [CUR_W-1:0]   lim_avg_high;
    logic [CUR_W-1:0]   lim_avg_low;
    logic [RATIO_W-1:0] lim_upper;
    logic [RATIO_W-1:0] lim_lower;
    logic [TIME_W-1:0]  lim_hold;
    logic               meter_armed [NUM_METERS];
    logic [TIME_W-1:0]  episode_start [NUM_METERS];
    logic               fault_expected [$];

    logic [TIME_W-1:0] clock_ms;
    int unsigned       step_max;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    bit                hold_req = 1'b0;
    int                mismatches = 0;
    int                result_count = 0;
    int                stall_cycles = 0;
    logic              expected_fault;

    phase_current_fault_detector DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .meter_index     (meter_index),
        .phase_a_current (phase_a_current),
        .phase_b_current (phase_b_current),
        .phase_c_current (phase_c_current),
        .average_current (average_current),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fault           (fault)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic currents_abnormal(input logic [CUR_W-1:0] a, b, c, avg);
        logic [CUR_W-1:0] hi;
        logic [CUR_W-1:0] lo;
        logic [31:0]      hi_lim;
        logic [31:0]      lo_lim;
        hi = a;
        lo = a;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        hi_lim = (32'(avg) * 32'(lim_upper)) / 32'd10;
        lo_lim = (32'(avg) * 32'(lim_lower)) / 32'd10;
        return (avg > lim_avg_high) || (avg != 0 && avg < lim_avg_low) ||
               (32'(hi) > hi_lim) || (lo != 0 && 32'(lo) < lo_lim);
    endfunction

    function automatic logic predict_fault(input logic [METER_W-1:0] m,
                                           input logic [CUR_W-1:0] a, b, c, avg,
                                           input logic [TIME_W-1:0] now);
        logic result;
        result = 1'b0;
        if (int'(m) < NUM_METERS)
        begin
            if (currents_abnormal(a, b, c, avg))
            begin
                if (meter_armed[m]) episode_start[m] = now;
                if (TIME_W'(now - episode_start[m]) > lim_hold) result = 1'b1;
                else meter_armed[m] = 1'b0;
            end
            else
            begin
                meter_armed[m] = 1'b1;
            end
        end
        return result;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcfd_pkg::REG_AVG_HIGH:    lim_avg_high = cfg_data[CUR_W-1:0];
                pcfd_pkg::REG_AVG_LOW:     lim_avg_low = cfg_data[CUR_W-1:0];
                pcfd_pkg::REG_UPPER_RATIO: lim_upper = cfg_data[RATIO_W-1:0];
                pcfd_pkg::REG_LOWER_RATIO: lim_lower = cfg_data[RATIO_W-1:0];
                pcfd_pkg::REG_HOLD:        lim_hold = cfg_data[TIME_W-1:0];
                default:                   ;
            endcase
        end
        if (rst_n && in_valid && in_ready)
        begin
            fault_expected.push_back(predict_fault(meter_index, phase_a_current, phase_b_current,
                phase_c_current, average_current, now_ms));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (fault_expected.size() == 0)
            begin
                if (mismatches < 10) $display("unexpected fault item %0b at %0t", fault, $realtime);
                mismatches++;
            end
            else
            begin
                expected_fault = fault_expected.pop_front();
                if (fault !== expected_fault)
                begin
                    if (mismatches < 10)
                        $display("fault mismatch on item %0d: expected %0b, got %0b",
                                 result_count, expected_fault, fault);
                    mismatches++;
                end
                result_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // The output side: random stalls, rare long ones, and a long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_stall_pct != 0 && $urandom_range(99, 0) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(40, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    function automatic int idle_gap();
        if ($urandom_range(99, 0) >= tx_idle_pct) return 0;
        if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [TIME_W-1:0] next_now();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3) clock_ms = $urandom();
        else if (r < 6) clock_ms = clock_ms - $urandom_range(1000, 1);
        else clock_ms = clock_ms + $urandom_range(step_max, 0);
        return clock_ms;
    endfunction

    task automatic send_reading(input logic [METER_W-1:0] m,
                                input logic [CUR_W-1:0] a, b, c, avg,
                                input logic [TIME_W-1:0] now);
        int gap;
        in_valid <= 1'b1;
        meter_index <= m;
        phase_a_current <= a;
        phase_b_current <= b;
        phase_c_current <= c;
        average_current <= avg;
        now_ms <= now;
        do @(posedge clk); while (!in_ready);
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_shaped(input logic [METER_W-1:0] m, input reading_kind_e kind);
        int avg;
        int hi_lim;
        int lo_lim;
        int pick;
        int ph [3];
        if (lim_avg_low <= lim_avg_high)
            avg = $urandom_range(lim_avg_high, (lim_avg_low == 0) ? 1 : lim_avg_low);
        else
            avg = $urandom_range(65535, 0);
        hi_lim = (avg * lim_upper) / 10;
        if (hi_lim > 65535) hi_lim = 65535;
        lo_lim = (avg * lim_lower) / 10;
        for (int i = 0; i < 3; i++)
            ph[i] = (lo_lim <= hi_lim) ? $urandom_range(hi_lim, lo_lim) : $urandom_range(65535, 0);
        pick = $urandom_range(2, 0);
        case (kind)
            READ_AVG_HIGH:
                if (lim_avg_high < 16'hFFFF) avg = $urandom_range(65535, int'(lim_avg_high) + 1);
            READ_AVG_LOW:
                if (lim_avg_low > 1) avg = $urandom_range(int'(lim_avg_low) - 1, 1);
            READ_PHASE_HIGH:
                if (hi_lim < 65535) ph[pick] = $urandom_range(65535, hi_lim + 1);
            READ_PHASE_LOW:
                if (lo_lim > 1) ph[pick] = $urandom_range(lo_lim - 1, 1);
            READ_NOISE:
            begin
                avg = $urandom_range(65535, 0);
                for (int i = 0; i < 3; i++) ph[i] = $urandom_range(65535, 0);
            end
            default: ;
        endcase
        send_reading(m, CUR_W'(ph[0]), CUR_W'(ph[1]), CUR_W'(ph[2]), CUR_W'(avg), next_now());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (fault_expected.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Unused upper data bits carry random junk, which the block must drop.
    task automatic set_config(input logic [CUR_W-1:0] high, low,
                              input logic [RATIO_W-1:0] upper, lower,
                              input logic [TIME_W-1:0] hold);
        wait_idle();
        write_reg(pcfd_pkg::REG_AVG_HIGH, {16'($urandom()), high});
        write_reg(pcfd_pkg::REG_AVG_LOW, {16'($urandom()), low});
        write_reg(pcfd_pkg::REG_UPPER_RATIO, {24'($urandom()), upper});
        write_reg(pcfd_pkg::REG_LOWER_RATIO, {24'($urandom()), lower});
        write_reg(pcfd_pkg::REG_HOLD, hold);
        cfg_valid <= 1'b0;
        @(posedge clk);
        step_max = (hold < 20000) ? hold / 3 + 20 : 3000;
    endtask

    task automatic run_episodes(input int items);
        int sent;
        int len;
        int r;
        logic [METER_W-1:0] m;
        reading_kind_e kind;
        sent = 0;
        while (sent < items)
        begin
            m = $urandom_range(NUM_METERS - 1, 0);
            len = $urandom_range(12, 2);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(99, 0);
                if (r < 10) kind = READ_NOISE;
                else if (r < 30) kind = READ_NORMAL;
                else kind = reading_kind_e'($urandom_range(READ_PHASE_LOW, READ_AVG_HIGH));
                if ($urandom_range(9, 0) == 0) send_shaped($urandom_range(NUM_METERS - 1, 0), kind);
                else send_shaped(m, kind);
                sent++;
            end
        end
    endtask

    // Runs at the reset configuration, so it also checks the register reset values.
    task automatic test_directed_readings();
        tx_idle_pct = 20;
        rx_stall_pct = 20;
        send_reading(2'd0, 16'd500, 16'd500, 16'd500, 16'd500, 32'd0);
        send_reading(2'd1, 16'd701, 16'd701, 16'd701, 16'd701, 32'd100);
        send_reading(2'd1, 16'd701, 16'd701, 16'd701, 16'd701, 32'd3100);
        send_reading(2'd1, 16'd701, 16'd701, 16'd701, 16'd701, 32'd3101);
        send_reading(2'd1, 16'd500, 16'd500, 16'd500, 16'd500, 32'd3200);
        send_reading(2'd2, 16'd359, 16'd359, 16'd359, 16'd359, 32'd1000);
        send_reading(2'd2, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5000);
        send_reading(2'd3, 16'd1, 16'd0, 16'd0, 16'd0, 32'd10);
        send_reading(2'd0, 16'd601, 16'd500, 16'd500, 16'd500, 32'd20);
        send_reading(2'd0, 16'd600, 16'd500, 16'd500, 16'd500, 32'd30);
        send_reading(2'd0, 16'd500, 16'd500, 16'd399, 16'd500, 32'd40);
        send_reading(2'd0, 16'd500, 16'd500, 16'd0, 16'd500, 32'd50);
        send_reading(2'd0, 16'd500, 16'd400, 16'd500, 16'd500, 32'd60);
        send_reading(2'd0, 16'd700, 16'd560, 16'd840, 16'd700, 32'd70);
        send_reading(2'd0, 16'd360, 16'd360, 16'd360, 16'd360, 32'd80);
        send_reading(2'd2, 16'd800, 16'd800, 16'd800, 16'd800, 32'hFFFF_FF00);
        send_reading(2'd2, 16'd800, 16'd800, 16'd800, 16'd800, 32'h0000_0A00);
        send_reading(2'd2, 16'd800, 16'd800, 16'd800, 16'd800, 32'hFFFF_F000);
        send_reading(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_reading(2'd1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_AAAA);
        send_reading(2'd1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_5555);
    endtask

    task automatic test_config_extremes();
        tx_idle_pct = 10;
        rx_stall_pct = 10;
        set_config(16'd0, 16'd0, 8'd0, 8'd0, 32'd0);
        send_reading(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd100);
        send_reading(2'd0, 16'd0, 16'd0, 16'd0, 16'd1, 32'd100);
        send_reading(2'd0, 16'd0, 16'd0, 16'd0, 16'd1, 32'd101);
        send_reading(2'd1, 16'd5, 16'd0, 16'd0, 16'd0, 32'd7);
        send_reading(2'd1, 16'd5, 16'd0, 16'd0, 16'd0, 32'd7);
        for (int i = 0; i < 6; i++) send_shaped($urandom_range(NUM_METERS - 1, 0), READ_NOISE);

        set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_reading(2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        send_reading(2'd2, 16'hFFFE, 16'h0, 16'h0, 16'hFFFE, 32'd1);
        send_reading(2'd2, 16'hFFFE, 16'h0, 16'h0, 16'hFFFE, 32'd0);
        for (int i = 0; i < 6; i++) send_shaped($urandom_range(NUM_METERS - 1, 0), READ_NOISE);

        // Writes to indexes past the last register must leave the configuration alone.
        wait_idle();
        for (int k = 1; pcfd_pkg::REG_HOLD + k < (1 << CFG_IDX_W); k++)
            write_reg(pcfd_pkg::REG_HOLD + CFG_IDX_W'(k), $urandom());
        cfg_valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 8; i++) send_shaped($urandom_range(NUM_METERS - 1, 0), READ_NOISE);
    endtask

    task automatic test_random_settings();
        logic [CUR_W-1:0] high;
        for (int phase = 0; phase < 4; phase++)
        begin
            high = $urandom_range(60000, 200);
            case (phase)
                0: set_config(pcfd_pkg::AVG_HIGH_RESET, pcfd_pkg::AVG_LOW_RESET,
                              pcfd_pkg::UPPER_RATIO_RESET, pcfd_pkg::LOWER_RATIO_RESET,
                              pcfd_pkg::HOLD_RESET);
                1: set_config(high, $urandom_range(high, 0), $urandom_range(30, 10),
                              $urandom_range(10, 0), $urandom_range(5000, 1));
                2: set_config(high, $urandom_range(high, 0), $urandom_range(30, 10),
                              $urandom_range(10, 0), 32'd0);
                default: set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            endcase
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 30; rx_stall_pct = 30; end
                2: begin tx_idle_pct = 10; rx_stall_pct = 50; end
                default: begin tx_idle_pct = 50; rx_stall_pct = 10; end
            endcase
            run_episodes(PHASE_ITEMS);
        end
    endtask

    // The output is held off while items keep coming, so the block fills and stalls its input.
    task automatic test_backpressure();
        set_config(pcfd_pkg::AVG_HIGH_RESET, pcfd_pkg::AVG_LOW_RESET, pcfd_pkg::UPPER_RATIO_RESET,
                   pcfd_pkg::LOWER_RATIO_RESET, 32'd500);
        tx_idle_pct = 0;
        rx_stall_pct = 20;
        hold_req = 1'b1;
        run_episodes(80);
        wait_idle();
    endtask

    initial
    begin
        lim_avg_high = pcfd_pkg::AVG_HIGH_RESET;
        lim_avg_low = pcfd_pkg::AVG_LOW_RESET;
        lim_upper = pcfd_pkg::UPPER_RATIO_RESET;
        lim_lower = pcfd_pkg::LOWER_RATIO_RESET;
        lim_hold = pcfd_pkg::HOLD_RESET;
        for (int i = 0; i < NUM_METERS; i++)
        begin
            meter_armed[i] = 1'b1;
            episode_start[i] = '0;
        end
        clock_ms = '0;
        step_max = 1020;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_readings();
        test_config_extremes();
        test_random_settings();
        test_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
